// ===== src/ktc_pkg.sv =====
// ktc_pkg: types and constants shared by the transposition cipher modules
// no dependencies
`timescale 1ns / 1ps

package ktc_pkg;

  localparam int unsigned KEY_SLOTS = 8;
  localparam int unsigned MAX_BLOCK = 8;
  localparam int unsigned BLOCK_CAP = (MAX_BLOCK < KEY_SLOTS) ? MAX_BLOCK : KEY_SLOTS;

  localparam logic [3:0] LEN_CAP = 4'(BLOCK_CAP);

  localparam logic [7:0] PAD_ENC   = 8'h7A;
  localparam logic [7:0] PAD_DEC   = 8'h5A;
  localparam logic [7:0] SPACE_CH  = 8'h20;
  localparam logic [7:0] CASE_STEP = 8'h20;

  localparam logic [1:0] REG_BLOCK_LEN = 2'd0;
  localparam logic [1:0] REG_KEY_ORDER = 2'd1;
  localparam logic [1:0] REG_DIRECTION = 2'd2;

  localparam logic [3:0]  RST_BLOCK_LEN = 4'd8;
  localparam logic [23:0] RST_KEY_ORDER = 24'hF4C688;

  // one finished block waiting in a buffer bank
  typedef struct packed {
    logic        bank;
    logic [3:0]  fill;
    logic [3:0]  len;
    logic [23:0] key;
    logic        dir;
  } ktc_desc_t;

  // byte write into the block buffer
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] data;
  } ktc_wr_t;

endpackage

// ===== src/ktc_front.sv =====
// ktc_front: config registers, byte intake and block completion detection
// depends on ktc_pkg
`timescale 1ns / 1ps

module ktc_front
  import ktc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [23:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             message_end,
  input  logic             q_full,
  output logic             push,
  output ktc_desc_t        desc,
  output ktc_wr_t          wr
);

  logic [3:0]  block_len;
  logic [23:0] key_order;
  logic        direction;
  logic [3:0]  fill;
  logic [3:0]  fill_next;
  logic        bank;
  logic [3:0]  eff_len;
  logic        accept;
  logic        done;

  always_comb begin
    if (block_len == 4'd0) begin
      eff_len = 4'd1;
    end else if (block_len > LEN_CAP) begin
      eff_len = LEN_CAP;
    end else begin
      eff_len = block_len;
    end
  end

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign fill_next = fill + 4'd1;
  assign done      = (fill_next >= eff_len) || message_end;

  assign wr.en   = accept;
  assign wr.addr = {bank, fill[2:0]};
  assign wr.data = in_byte;

  assign push      = accept && done;
  assign desc.bank = bank;
  assign desc.fill = fill_next;
  assign desc.len  = eff_len;
  assign desc.key  = key_order;
  assign desc.dir  = direction;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len <= RST_BLOCK_LEN;
      key_order <= RST_KEY_ORDER;
      direction <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_LEN: block_len <= cfg_data[3:0];
        REG_KEY_ORDER: key_order <= cfg_data;
        REG_DIRECTION: direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 4'd0;
      bank <= 1'b0;
    end else if (accept) begin
      if (done) begin
        fill <= 4'd0;
        bank <= ~bank;
      end else begin
        fill <= fill_next;
      end
    end
  end

endmodule

// ===== src/ktc_queue.sv =====
// ktc_queue: two-entry descriptor queue between intake and output sides
// depends on ktc_pkg
`timescale 1ns / 1ps

module ktc_queue
  import ktc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ktc_desc_t desc_in,
  input  logic      pop,
  output ktc_desc_t head,
  output logic      head_valid,
  output logic      full
);

  ktc_desc_t   slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= desc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full descriptor queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty descriptor queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("descriptor count out of range");

endmodule

// ===== src/ktc_back.sv =====
// ktc_back: double-banked block buffer and permuted byte emission
// depends on ktc_pkg
`timescale 1ns / 1ps

module ktc_back
  import ktc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ktc_wr_t    wr,
  input  ktc_desc_t  head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       block_last
);

  logic [7:0] mem [2*KEY_SLOTS];

  logic [2:0] idx;
  logic [2:0] src;
  logic       src_ok;
  logic       a_ok;
  logic       b_ok;
  logic       last;
  logic       issue;
  logic       issue_ok;
  logic       out_load;
  logic       advance;

  logic       r_valid;
  logic [7:0] rd_a;
  logic [7:0] rd_b;
  logic       r_a_ok;
  logic       r_b_ok;
  logic       r_dir;
  logic       r_last;

  logic [7:0] pad;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [7:0] value;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // source position for output idx; decrypt inverts the key, later entries win
  always_comb begin
    src    = head.key[3*idx +: 3];
    src_ok = ({1'b0, src} < head.len);
    if (head.dir) begin
      src    = 3'd0;
      src_ok = 1'b0;
      for (int jj = 0; jj < KEY_SLOTS; jj++) begin
        if ((4'(jj) < head.len) && (head.key[3*jj +: 3] == idx)) begin
          src    = 3'(jj);
          src_ok = 1'b1;
        end
      end
    end
  end

  // positions at or past the fill count are padding
  assign a_ok = ({1'b0, idx} < head.fill);
  assign b_ok = src_ok && ({1'b0, src} < head.fill);
  assign last = ({1'b0, idx} == (head.len - 4'd1));

  assign out_load = !out_valid || out_ready;
  assign advance  = r_valid && out_load;
  assign issue_ok = !r_valid || out_load;
  assign issue    = head_valid && issue_ok;
  assign pop      = issue && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (issue) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_a   <= mem[{head.bank, idx}];
      rd_b   <= mem[{head.bank, src}];
      r_a_ok <= a_ok;
      r_b_ok <= b_ok;
      r_dir  <= head.dir;
      r_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (issue) begin
      r_valid <= 1'b1;
    end else if (advance) begin
      r_valid <= 1'b0;
    end
  end

  assign pad    = r_dir ? PAD_DEC : PAD_ENC;
  assign byte_a = r_a_ok ? rd_a : pad;
  assign byte_b = r_b_ok ? rd_b : pad;

  always_comb begin
    if (byte_a == SPACE_CH) begin
      value = SPACE_CH;
    end else if (r_dir) begin
      value = byte_b + CASE_STEP;
    end else begin
      value = byte_b - CASE_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= value;
      block_last <= r_last;
    end
  end

  a_idx_in_block: assert property (@(posedge clk) disable iff (rst)
    issue |-> ({1'b0, idx} < head.len))
    else $error("output index past block length");
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !out_load) |=> (r_valid && $stable(rd_a) && $stable(rd_b)))
    else $error("read stage lost data while stalled");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(block_last)))
    else $error("output beat changed while stalled");

endmodule

// ===== src/keyed_transposition_cipher.sv =====
// keyed transposition cipher: bytes in, permuted and case-shifted blocks out
// after its closing beat, a block leaves via a read stage and an output register
// throughput: one byte per cycle in and out while neither side is stalled;
// the output side is bounded by the single-issue read of the two-bank block buffer
// intake stalls only while two finished blocks wait for output
// rst is synchronous: registers return to their reset values, buffer contents persist
`timescale 1ns / 1ps

module keyed_transposition_cipher
  import ktc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        block_last
);

  ktc_desc_t desc;
  ktc_desc_t head;
  ktc_wr_t   wr;
  logic      push;
  logic      pop;
  logic      head_valid;
  logic      q_full;

  ktc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .message_end (message_end),
    .q_full      (q_full),
    .push        (push),
    .desc        (desc),
    .wr          (wr)
  );

  ktc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .desc_in    (desc),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  ktc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .block_last (block_last)
  );

endmodule

// ===== dv/testbench.sv =====
// testbench for keyed_transposition_cipher: a directed table, then random phases
// checked byte by byte against a block-level predictor of the cipher
// depends on ktc_pkg and the cipher rtl
`timescale 1ns / 1ps

module testbench;
  import ktc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [23:0] val;
    logic [7:0]  ch;
    logic        fin;
    logic [7:0]  want;
  } plan_row_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        message_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        block_last;

  // shadow of the cipher state and its registers
  logic [7:0]  buf_mirror [KEY_SLOTS];
  logic [3:0]  fill_mirror;
  logic [3:0]  len_reg;
  logic [23:0] key_reg;
  logic        dir_reg;

  out_beat_t   expected_beats [$];
  plan_row_t   plan [$];
  out_beat_t   want_beat;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          steady = 1'b0;

  keyed_transposition_cipher i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .message_end (message_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .block_last  (block_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned eff_len();
    int unsigned l;
    l = 32'(len_reg);
    if (l < 1) l = 1;
    if (l > BLOCK_CAP) l = BLOCK_CAP;
    return l;
  endfunction

  function automatic int unsigned key_at(int unsigned j);
    return 32'(key_reg[3*j +: 3]);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("mismatch at %0t ns: %s got %02h want %02h", $time, what, got, want);
  endtask

  // store one byte; on a full block or message end, queue the whole output block
  task automatic transpose_step(input logic [7:0] ch, input logic fin);
    int unsigned l, j, k, s;
    int unsigned src [KEY_SLOTS];
    logic [7:0]  pad, b;
    out_beat_t   beat;
    l = eff_len();
    pad = dir_reg ? PAD_DEC : PAD_ENC;
    buf_mirror[fill_mirror[2:0]] = ch;
    fill_mirror = fill_mirror + 4'd1;
    if (fill_mirror < l && !fin) return;
    for (j = 32'(fill_mirror); j < l; j++) buf_mirror[j] = pad;
    for (j = 0; j < KEY_SLOTS; j++) src[j] = dir_reg ? KEY_SLOTS : key_at(j);
    // inverse key: later entries win, unset slots stay out of range
    if (dir_reg) begin
      for (j = 0; j < l; j++) begin
        k = key_at(j);
        if (k < l) src[k] = j;
      end
    end
    for (j = 0; j < l; j++) begin
      if (buf_mirror[j] == SPACE_CH) begin
        beat.byte_val = SPACE_CH;
      end else begin
        s = src[j];
        b = (s < l) ? buf_mirror[s] : pad;
        beat.byte_val = dir_reg ? b + CASE_STEP : b - CASE_STEP;
      end
      beat.last = (j == l - 1);
      expected_beats.push_back(beat);
    end
    fill_mirror = 4'd0;
  endtask

  // entered and left at a falling edge; valid stays up when the next beat follows at once
  task automatic send_byte(input logic [7:0] ch, input logic fin, input logic typed,
                           input logic [7:0] want);
    int unsigned gap;
    out_beat_t   beat;
    gap = steady ? 0 : gap_len();
    cfg_we = 1'b0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = ch;
    message_end = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    transpose_step(ch, fin);
    if (typed) begin
      beat = expected_beats.pop_back();
      beat.byte_val = want;
      beat.last = 1'b1;
      expected_beats.push_back(beat);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_BLOCK_LEN: len_reg = val[3:0];
      REG_KEY_ORDER: key_reg = val;
      REG_DIRECTION: dir_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // wait for every queued block byte, then drain with input and register writes held off
  task automatic settle();
    in_valid = 1'b0;
    cfg_we = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [23:0] val);
    plan_row_t p;
    p = '0;
    p.kind = ROW_CFG;
    p.idx = idx;
    p.val = val;
    return p;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] ch, input logic fin);
    plan_row_t p;
    p = '0;
    p.kind = ROW_BYTE;
    p.ch = ch;
    p.fin = fin;
    return p;
  endfunction

  function automatic plan_row_t typed_row(input logic [7:0] ch, input logic [7:0] want);
    plan_row_t p;
    p = '0;
    p.kind = ROW_TYPED;
    p.ch = ch;
    p.want = want;
    return p;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, byte", out_byte, 8'h00);
      end else begin
        want_beat = expected_beats.pop_front();
        if (out_byte !== want_beat.byte_val)
          report_mismatch("out_byte", out_byte, want_beat.byte_val);
        if (block_last !== want_beat.last)
          report_mismatch("block_last", {7'd0, block_last}, {7'd0, want_beat.last});
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: runs of ready with random stalls
  initial begin : sink
    int unsigned n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      n = ($urandom_range(0, 9) < 2) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      out_ready = 1'b1;
      repeat (n) @(negedge clk);
      n = gap_len();
      if (n != 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned sent, count, i, l, r, t;
    int unsigned perm [KEY_SLOTS];
    logic [23:0] key;
    logic [7:0]  ch;
    logic        fin;
    bit          first_phase, prev_cfg;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BLOCK_LEN;
    cfg_data = '0;
    in_valid = 1'b0;
    in_byte = '0;
    message_end = 1'b0;
    for (i = 0; i < KEY_SLOTS; i++) buf_mirror[i] = '0;
    fill_mirror = 4'd0;
    len_reg = RST_BLOCK_LEN;
    key_reg = RST_KEY_ORDER;
    dir_reg = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: one full block, then a short message that gets padded
    plan.push_back(byte_row("a", 1'b0));
    plan.push_back(byte_row("b", 1'b0));
    plan.push_back(byte_row(" ", 1'b0));
    plan.push_back(byte_row("c", 1'b0));
    plan.push_back(byte_row("d", 1'b0));
    plan.push_back(byte_row("e", 1'b0));
    plan.push_back(byte_row("f", 1'b0));
    plan.push_back(byte_row("g", 1'b0));
    plan.push_back(byte_row("x", 1'b0));
    plan.push_back(byte_row("y", 1'b1));
    // zero length acts as one, identity key
    plan.push_back(cfg_row(REG_BLOCK_LEN, 24'd0));
    plan.push_back(cfg_row(REG_KEY_ORDER, 24'd0));
    plan.push_back(typed_row(8'h61, 8'h41));
    plan.push_back(typed_row(8'h00, 8'hE0));
    plan.push_back(typed_row(8'hFF, 8'hDF));
    plan.push_back(typed_row(8'h20, 8'h20));
    plan.push_back(cfg_row(REG_DIRECTION, 24'd1));
    plan.push_back(typed_row(8'h41, 8'h61));
    plan.push_back(typed_row(8'hFF, 8'h1F));
    // key entry past the block: pad byte, then the case shift
    plan.push_back(cfg_row(REG_KEY_ORDER, 24'd5));
    plan.push_back(typed_row(8'h41, 8'h7A));
    plan.push_back(cfg_row(REG_DIRECTION, 24'd0));
    plan.push_back(typed_row(8'h41, 8'h5A));
    // oversize length saturates, key with all entries equal
    plan.push_back(cfg_row(REG_BLOCK_LEN, 24'd15));
    plan.push_back(cfg_row(REG_KEY_ORDER, 24'hFFFFFF));
    plan.push_back(byte_row("p", 1'b0));
    plan.push_back(byte_row("q", 1'b0));
    plan.push_back(byte_row("r", 1'b1));
    // length shrinks below the fill of an open block
    plan.push_back(cfg_row(REG_BLOCK_LEN, 24'd8));
    plan.push_back(cfg_row(REG_KEY_ORDER, 24'o01234567));
    plan.push_back(byte_row("m", 1'b0));
    plan.push_back(byte_row("n", 1'b0));
    plan.push_back(byte_row("o", 1'b0));
    plan.push_back(byte_row("p", 1'b0));
    plan.push_back(cfg_row(REG_BLOCK_LEN, 24'd2));
    plan.push_back(byte_row("q", 1'b0));

    prev_cfg = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        if (!prev_cfg) settle();
        write_reg(plan[k].idx, plan[k].val);
        prev_cfg = 1'b1;
      end else begin
        send_byte(plan[k].ch, plan[k].fin, plan[k].kind == ROW_TYPED, plan[k].want);
        prev_cfg = 1'b0;
      end
    end

    sent = 0;
    first_phase = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      settle();
      steady = ($urandom_range(0, 9) < 3);
      if (first_phase || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 8) l = 0;
        else if (r < 16) l = $urandom_range(9, 15);
        else if (r < 26) l = 1;
        else if (r < 36) l = 8;
        else l = $urandom_range(1, 8);
        write_reg(REG_BLOCK_LEN, 24'(l));
      end
      if (first_phase || $urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // permutation over the live block, random entries above it
          l = eff_len();
          for (i = 0; i < KEY_SLOTS; i++) perm[i] = i;
          for (i = l; i > 1; i--) begin
            r = $urandom_range(0, i - 1);
            t = perm[i - 1];
            perm[i - 1] = perm[r];
            perm[r] = t;
          end
          key = 24'($urandom);
          for (i = 0; i < l; i++) key[3*i +: 3] = 3'(perm[i]);
        end else if (r < 80) begin
          key = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
        end else begin
          key = 24'($urandom);
        end
        write_reg(REG_KEY_ORDER, key);
      end
      if (first_phase || $urandom_range(0, 1))
        write_reg(REG_DIRECTION, 24'($urandom_range(0, 1)));
      first_phase = 1'b0;

      count = $urandom_range(6, 48);
      for (i = 0; i < count; i++) begin
        r = $urandom_range(0, 99);
        if (r < 40) ch = 8'($urandom_range(8'h61, 8'h7A));
        else if (r < 60) ch = 8'($urandom_range(8'h41, 8'h5A));
        else if (r < 75) ch = SPACE_CH;
        else ch = 8'($urandom);
        // the last beat of a phase may leave the block open across a register change
        fin = ($urandom_range(0, 99) < 8) || (i == count - 1 && $urandom_range(0, 1));
        send_byte(ch, fin, 1'b0, 8'h00);
        sent++;
      end
    end

    settle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ktc_pkg.sv
src/ktc_front.sv
src/ktc_queue.sv
src/ktc_back.sv
src/keyed_transposition_cipher.sv
dv/testbench.sv
